>>> hw/rtl/svv_pkg.sv
// ----------------------------------------------------------------------------
// svv_pkg - semantic version validator package
// Shared constants, result type and character class helpers.
// ----------------------------------------------------------------------------
package svv_pkg;

	localparam int COUNT_WIDTH = 8;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;
	typedef logic [7:0]             char_t;
	typedef logic [2:0]             phase_t;

	localparam cnt_t CNT_MAX = {COUNT_WIDTH{1'b1}};

	localparam char_t CH_NUL  = 8'h00;
	localparam char_t CH_DOT  = 8'h2E;
	localparam char_t CH_DASH = 8'h2D;
	localparam char_t CH_PLUS = 8'h2B;
	localparam char_t CH_ZERO = 8'h30;
	localparam char_t CH_NINE = 8'h39;
	localparam char_t CH_UC_A = 8'h41;
	localparam char_t CH_UC_Z = 8'h5A;
	localparam char_t CH_LC_A = 8'h61;
	localparam char_t CH_LC_Z = 8'h7A;

	localparam phase_t PH_MAJOR = 3'd0;
	localparam phase_t PH_MINOR = 3'd1;
	localparam phase_t PH_PATCH = 3'd2;
	localparam phase_t PH_PRE   = 3'd3;
	localparam phase_t PH_BUILD = 3'd4;

	typedef struct packed {
		logic       valid_res;
		logic       has_prerelease;
		logic       has_build;
		logic [7:0] major_digits;
		logic [7:0] minor_digits;
		logic [7:0] patch_digits;
		logic [7:0] prerelease_chars;
	} res_t;

	function automatic logic is_digit(char_t c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_ident(char_t c);
		return is_digit(c) || ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
			((c >= CH_LC_A) && (c <= CH_LC_Z)) || (c == CH_DASH);
	endfunction

	function automatic cnt_t sat_inc(cnt_t v);
		return (v == CNT_MAX) ? v : v + cnt_t'(1);
	endfunction

	function automatic logic [7:0] clamp8(cnt_t v);
		return (32'(v) > 32'd255) ? 8'hFF : 8'(v);
	endfunction

endpackage

>>> hw/rtl/svv_char_if.sv
// ----------------------------------------------------------------------------
// svv_char_if - character channel
// Valid/ready channel carrying one ASCII byte per transfer.
// ----------------------------------------------------------------------------
interface svv_char_if;
	logic               valid;
	logic               ready;
	svv_pkg::char_t     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/svv_res_if.sv
// ----------------------------------------------------------------------------
// svv_res_if - result channel
// Valid/ready channel carrying one validation result per transfer.
// ----------------------------------------------------------------------------
interface svv_res_if;
	logic               valid;
	logic               ready;
	svv_pkg::res_t      data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/svv_in_stage.sv
// ----------------------------------------------------------------------------
// svv_in_stage - input register
// Registers each incoming character; refills in the same cycle it drains.
// ----------------------------------------------------------------------------
module svv_in_stage (
	input  logic        clk,
	input  logic        arst_n,
	svv_char_if.sink    text,
	svv_char_if.source  mid
);
	import svv_pkg::*;

	logic  valid_s1;
	char_t char_s1;

	assign text.ready = !valid_s1 || mid.ready;
	assign mid.valid  = valid_s1;
	assign mid.data   = char_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			char_s1 <= text.data;
		end
	end

endmodule

>>> hw/rtl/svv_parse.sv
// ----------------------------------------------------------------------------
// svv_parse - version string parser
// Per-character state update and result register; a terminator loads the
// result and returns the parser state to its reset values.
// ----------------------------------------------------------------------------
module svv_parse (
	input  logic        clk,
	input  logic        arst_n,
	svv_char_if.sink    mid,
	svv_res_if.source   result
);
	import svv_pkg::*;

	phase_t     phase_q, phase_d;
	logic       failed_q, failed_d;
	cnt_t       run_q, run_d;
	logic       fz_q, fz_d;
	logic       all_dig_q, all_dig_d;
	cnt_t       major_q, major_d;
	cnt_t       minor_q, minor_d;
	cnt_t       patch_q, patch_d;
	cnt_t       pre_q, pre_d;
	logic [1:0] seen_q, seen_d;
	logic       res_valid_q;
	res_t       res_q, res_d;

	logic       take, is_term, close_bad, ok;
	char_t      ch;

	assign ch           = mid.data;
	assign is_term      = (ch == CH_NUL);
	assign mid.ready    = !is_term || !res_valid_q || result.ready;
	assign take         = mid.valid && mid.ready;
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	assign close_bad = (run_q == '0) ||
		((phase_q == PH_PRE) && all_dig_q && (run_q > cnt_t'(1)) && fz_q);

	always_comb begin
		phase_d   = phase_q;
		failed_d  = failed_q;
		run_d     = run_q;
		fz_d      = fz_q;
		all_dig_d = all_dig_q;
		major_d   = major_q;
		minor_d   = minor_q;
		patch_d   = patch_q;
		pre_d     = pre_q;
		seen_d    = seen_q;
		ok        = 1'b0;
		res_d     = '0;

		if (take && !is_term && !failed_q) begin
			if (phase_q <= PH_PATCH) begin
				if (is_digit(ch)) begin
					if (run_q == '0) begin
						fz_d = (ch == CH_ZERO);
					end else if (fz_q) begin
						failed_d = 1'b1;
					end
					run_d = sat_inc(run_q);
				end else if (run_q == '0) begin
					failed_d = 1'b1;
				end else if ((phase_q != PH_PATCH) && (ch == CH_DOT)) begin
					if (phase_q == PH_MAJOR) begin
						major_d = run_q;
					end else begin
						minor_d = run_q;
					end
					phase_d   = phase_q + phase_t'(1);
					run_d     = '0;
					fz_d      = 1'b0;
					all_dig_d = 1'b1;
				end else if ((phase_q == PH_PATCH) &&
						((ch == CH_DASH) || (ch == CH_PLUS))) begin
					patch_d = run_q;
					if (ch == CH_DASH) begin
						phase_d   = PH_PRE;
						seen_d[0] = 1'b1;
					end else begin
						phase_d   = PH_BUILD;
						seen_d[1] = 1'b1;
					end
					run_d     = '0;
					fz_d      = 1'b0;
					all_dig_d = 1'b1;
				end else begin
					failed_d = 1'b1;
				end
			end else if ((phase_q == PH_PRE) || (phase_q == PH_BUILD)) begin
				if (is_ident(ch)) begin
					if (run_q == '0) begin
						fz_d = (ch == CH_ZERO);
					end
					if (!is_digit(ch)) begin
						all_dig_d = 1'b0;
					end
					run_d = sat_inc(run_q);
					if (phase_q == PH_PRE) begin
						pre_d = sat_inc(pre_q);
					end
				end else if (ch == CH_DOT) begin
					if (close_bad) begin
						failed_d = 1'b1;
					end
					if (phase_q == PH_PRE) begin
						pre_d = sat_inc(pre_q);
					end
					run_d     = '0;
					fz_d      = 1'b0;
					all_dig_d = 1'b1;
				end else if ((ch == CH_PLUS) && (phase_q == PH_PRE)) begin
					if (close_bad) begin
						failed_d = 1'b1;
					end
					phase_d   = PH_BUILD;
					seen_d[1] = 1'b1;
					run_d     = '0;
					fz_d      = 1'b0;
					all_dig_d = 1'b1;
				end else begin
					failed_d = 1'b1;
				end
			end else begin
				failed_d = 1'b1;
			end
		end else if (take && is_term) begin
			if (!failed_q) begin
				if (phase_q == PH_PATCH) begin
					ok = (run_q != '0);
				end else if ((phase_q == PH_PRE) || (phase_q == PH_BUILD)) begin
					ok = !close_bad;
				end
			end
			if (ok) begin
				res_d.valid_res        = 1'b1;
				res_d.has_prerelease   = seen_q[0];
				res_d.has_build        = seen_q[1];
				res_d.major_digits     = clamp8(major_q);
				res_d.minor_digits     = clamp8(minor_q);
				res_d.patch_digits     = clamp8((phase_q == PH_PATCH) ? run_q : patch_q);
				res_d.prerelease_chars = clamp8(pre_q);
			end
			phase_d   = PH_MAJOR;
			failed_d  = 1'b0;
			run_d     = '0;
			fz_d      = 1'b0;
			all_dig_d = 1'b1;
			major_d   = '0;
			minor_d   = '0;
			patch_d   = '0;
			pre_d     = '0;
			seen_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MAJOR;
			failed_q    <= 1'b0;
			run_q       <= '0;
			fz_q        <= 1'b0;
			all_dig_q   <= 1'b1;
			major_q     <= '0;
			minor_q     <= '0;
			patch_q     <= '0;
			pre_q       <= '0;
			seen_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			failed_q  <= failed_d;
			run_q     <= run_d;
			fz_q      <= fz_d;
			all_dig_q <= all_dig_d;
			major_q   <= major_d;
			minor_q   <= minor_d;
			patch_q   <= patch_d;
			pre_q     <= pre_d;
			seen_q    <= seen_d;
			if (take && is_term) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_term) begin
			res_q <= res_d;
		end
	end

endmodule

>>> hw/rtl/semver_string_validator.sv
// ----------------------------------------------------------------------------
// semver_string_validator - semantic version 2.0.0 string checker
// Checks major.minor.patch[-pre][+build] strings one byte at a time.
// ----------------------------------------------------------------------------
// Usage:
//   text   : one ASCII byte per transfer; a zero byte ends the string.
//   result : one transfer per string, issued for the zero byte only:
//            valid flag, pre-release/build presence and part lengths.
//            An invalid string reports all fields zero.
// Timing:
//   One byte per cycle sustained while no zero byte is held back by an
//   unaccepted result. A byte is registered in the input register, then
//   updates the parser state; a zero byte loads the result register from
//   the parser. The per-byte state update between input and result
//   registers sets the rate.
// Stall:
//   While a result waits unaccepted, ordinary bytes keep flowing; only the
//   next zero byte holds in the input register until the result drains.
// Reset:
//   arst_n clears both registers' valid flags and puts the parser at the
//   start of a fresh string.
// ----------------------------------------------------------------------------
module semver_string_validator (
	input  logic        clk,
	input  logic        arst_n,
	svv_char_if.sink    text,
	svv_res_if.source   result
);
	import svv_pkg::*;

	svv_char_if mid ();

	svv_in_stage u_in_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.mid    (mid)
	);

	svv_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.mid    (mid),
		.result (result)
	);

	a_res_after_term: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(mid.valid && mid.ready && (mid.data == CH_NUL)))
		else $error("result raised without a terminator transfer");

	a_no_res_on_char: assert property (@(posedge clk) disable iff (!arst_n)
		(!result.valid && mid.valid && mid.ready && (mid.data != CH_NUL)) |=> !result.valid)
		else $error("result raised by a non-terminator");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.data.valid_res) |->
		(!result.data.has_prerelease && !result.data.has_build &&
		(result.data.major_digits == 8'd0) && (result.data.minor_digits == 8'd0) &&
		(result.data.patch_digits == 8'd0) && (result.data.prerelease_chars == 8'd0)))
		else $error("invalid result with non-zero fields");

	a_valid_parts: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.valid_res) |->
		((result.data.major_digits != 8'd0) && (result.data.minor_digits != 8'd0) &&
		(result.data.patch_digits != 8'd0)))
		else $error("valid result with an empty numeric part");

endmodule
